FILE: src/gprw_pkg.sv
// ----------------------------------------------------------------------------
// gprw_pkg
// Shared types and constants for the glyph row pixel writer.
// ----------------------------------------------------------------------------
`default_nettype none

package gprw_pkg;

	localparam int GLYPH_WIDTH  = 8;
	localparam int GLYPH_HEIGHT = 16;
	localparam int ADDRESS_BITS = 26;
	localparam int COL_W        = $clog2(GLYPH_WIDTH);

	localparam int CX_W     = 12;
	localparam int CY_W     = 12;
	localparam int ROW_W    = 4;
	localparam int BITS_W   = 8;
	localparam int COLOR_W  = 24;
	localparam int FMT_W    = 2;
	localparam int LINE_W   = 15;
	localparam int BADDR_W  = 26;
	localparam int WORD_W   = 24;
	localparam int BCOUNT_W = 3;

	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 56;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_BYTES   = 2'd1;

	localparam logic [FMT_W-1:0] FMT_XRGB   = 2'd0;
	localparam logic [FMT_W-1:0] FMT_RGB565 = 2'd1;
	localparam logic [FMT_W-1:0] FMT_PAL8   = 2'd2;

	localparam logic [BCOUNT_W-1:0] BC_XRGB   = 3'd4;
	localparam logic [BCOUNT_W-1:0] BC_RGB565 = 3'd2;
	localparam logic [BCOUNT_W-1:0] BC_PAL8   = 3'd1;

	typedef struct packed {
		logic [COLOR_W-1:0] fg_color;
		logic [BITS_W-1:0]  glyph_bits;
		logic [ROW_W-1:0]   row_index;
		logic [CY_W-1:0]    char_y;
		logic [CX_W-1:0]    char_x;
	} in_item_t;

	typedef struct packed {
		logic [ADDRESS_BITS-1:0] base;
		logic [CX_W-1:0]         char_x;
		logic [BITS_W-1:0]       glyph_bits;
		logic [COLOR_W-1:0]      fg_color;
		logic [FMT_W-1:0]        fmt;
		logic [BCOUNT_W-1:0]     byte_count;
	} row_t;

	typedef struct packed {
		logic [ADDRESS_BITS-1:0] addr;
		logic [WORD_W-1:0]       word;
	} pix_t;

endpackage

`default_nettype wire

FILE: src/gprw_front.sv
// ----------------------------------------------------------------------------
// gprw_front
// Input stage and row base multiply: (char_y + row_index) * line_bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module gprw_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire gprw_pkg::in_item_t          in_item,
	input  wire logic [gprw_pkg::FMT_W-1:0]  pixel_format,
	input  wire logic [gprw_pkg::LINE_W-1:0] line_bytes,
	output logic                             row_valid,
	input  wire logic                        row_ready,
	output gprw_pkg::row_t                   row
);
	import gprw_pkg::*;

	localparam int SUM_W  = CY_W + 1;
	localparam int PROD_W = SUM_W + LINE_W;

	logic                    v_s1;
	logic                    skip_s1;
	logic [SUM_W-1:0]        line_s1;
	logic [CX_W-1:0]         cx_s1;
	logic [BITS_W-1:0]       bits_s1;
	logic [COLOR_W-1:0]      color_s1;
	logic                    v_s2;
	row_t                    row_s2;
	logic                    ready_s2;
	logic                    accept;
	logic                    skip;
	logic [PROD_W-1:0]       prod;
	logic [BCOUNT_W-1:0]     bcount;

	assign ready_s2 = !v_s2 || row_ready;
	assign in_ready = !v_s1 || ready_s2;
	assign accept   = in_valid && in_ready;
	assign skip     = (pixel_format > FMT_PAL8) || (int'(in_item.row_index) >= GLYPH_HEIGHT);
	assign prod     = PROD_W'(line_s1) * PROD_W'(line_bytes);

	always_comb begin
		unique case (pixel_format)
			FMT_XRGB:   bcount = BC_XRGB;
			FMT_RGB565: bcount = BC_RGB565;
			default:    bcount = BC_PAL8;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (ready_s2) begin
				v_s1 <= 1'b0;
			end
			if (ready_s2) begin
				v_s2 <= v_s1 && !skip_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			skip_s1  <= skip;
			line_s1  <= SUM_W'(in_item.char_y) + SUM_W'(in_item.row_index);
			cx_s1    <= in_item.char_x;
			bits_s1  <= in_item.glyph_bits;
			color_s1 <= in_item.fg_color;
		end
		if (ready_s2 && v_s1) begin
			row_s2.base       <= ADDRESS_BITS'(prod);
			row_s2.char_x     <= cx_s1;
			row_s2.glyph_bits <= bits_s1;
			row_s2.fg_color   <= color_s1;
			row_s2.fmt        <= pixel_format;
			row_s2.byte_count <= bcount;
		end
	end

	assign row_valid = v_s2;
	assign row       = row_s2;

endmodule

`default_nettype wire

FILE: src/gprw_lane.sv
// ----------------------------------------------------------------------------
// gprw_lane
// One pixel column: byte address and packed pixel value.
// ----------------------------------------------------------------------------
`default_nettype none

module gprw_lane (
	input  wire gprw_pkg::row_t             row,
	input  wire logic [gprw_pkg::COL_W-1:0] col,
	input  wire logic                       pix_on,
	output gprw_pkg::pix_t                  pix
);
	import gprw_pkg::*;

	localparam int XS_W  = CX_W + 1;
	localparam int OFS_W = XS_W + 2;

	logic [XS_W-1:0]    xs;
	logic [OFS_W-1:0]   ofs;
	logic [WORD_W-1:0]  fg;

	assign xs = XS_W'(row.char_x) + XS_W'(col);

	always_comb begin
		unique case (row.fmt)
			FMT_XRGB: begin
				ofs = {xs, 2'b00};
				fg  = row.fg_color;
			end
			FMT_RGB565: begin
				ofs = {1'b0, xs, 1'b0};
				fg  = WORD_W'({row.fg_color[23:19], row.fg_color[15:10], row.fg_color[7:3]});
			end
			default: begin
				ofs = {2'b00, xs};
				fg  = WORD_W'(row.fg_color[7:0]);
			end
		endcase
	end

	assign pix.addr = row.base + ADDRESS_BITS'(ofs);
	assign pix.word = pix_on ? fg : '0;

endmodule

`default_nettype wire

FILE: src/gprw_merge.sv
// ----------------------------------------------------------------------------
// gprw_merge
// Row buffer for the lane results, sent out one pixel per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module gprw_merge (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               row_valid,
	output logic                                    row_ready,
	input  wire logic [gprw_pkg::BCOUNT_W-1:0]      row_bcount,
	input  wire gprw_pkg::pix_t                     pix [gprw_pkg::GLYPH_WIDTH],
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic [gprw_pkg::OUT_DATA_W-1:0]         m_tdata,
	output logic                                    m_tlast
);
	import gprw_pkg::*;

	localparam logic [COL_W-1:0] LAST_COL = COL_W'(GLYPH_WIDTH - 1);
	localparam int PAD_W = OUT_DATA_W - BADDR_W - WORD_W - BCOUNT_W;

	pix_t                pix_s3 [GLYPH_WIDTH];
	logic [BCOUNT_W-1:0] bcount_q;
	logic [COL_W-1:0]    col_q;
	logic                busy_q;
	logic                xfer;
	logic                load;
	pix_t                cur;

	assign xfer      = busy_q && m_tready;
	assign row_ready = !busy_q || (xfer && col_q == LAST_COL);
	assign load      = row_valid && row_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			col_q  <= '0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				col_q  <= '0;
			end else if (xfer) begin
				col_q <= col_q + 1'b1;
				if (col_q == LAST_COL) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pix_s3   <= pix;
			bcount_q <= row_bcount;
		end
	end

	assign cur      = pix_s3[col_q];
	assign m_tvalid = busy_q;
	assign m_tlast  = (col_q == LAST_COL);
	assign m_tdata  = {PAD_W'(0), bcount_q, cur.word, BADDR_W'(cur.addr)};

endmodule

`default_nettype wire

FILE: src/glyph_row_pixel_writer.sv
// ----------------------------------------------------------------------------
// glyph_row_pixel_writer
// Blits one 8-pixel glyph row into framebuffer pixel writes.
// ----------------------------------------------------------------------------
// Each input transfer carries one glyph row and yields eight output transfers,
// leftmost pixel first, tlast on the eighth. The output port moves one pixel
// per cycle while m_tready is high; the next row is taken and prepared while
// the current one drains. The first pixel passes through the input register,
// the row base multiply register and the lane buffer, and waits while the
// buffer is busy. Rows with row_index beyond the glyph height, or sent while
// pixel_format is 3, produce no output. Configuration writes are accepted at
// any time but must only be issued while the block is idle.
`default_nettype none

module glyph_row_pixel_writer (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// char_x[11:0], char_y[23:12], row_index[27:24], glyph_bits[35:28],
	// fg_color[59:36], zero pad
	input  wire logic [gprw_pkg::IN_DATA_W-1:0]    s_tdata,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// byte_address[25:0], pixel_word[49:26], byte_count[52:50], zero pad
	output logic [gprw_pkg::OUT_DATA_W-1:0]        m_tdata,
	output logic                                   m_tlast,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [gprw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [gprw_pkg::LINE_W-1:0]       cfg_data
);
	import gprw_pkg::*;

	logic [FMT_W-1:0]  pixel_format_q;
	logic [LINE_W-1:0] line_bytes_q;
	in_item_t          in_item;
	logic              row_valid;
	logic              row_ready;
	row_t              row;
	pix_t              pix [GLYPH_WIDTH];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_format_q <= FMT_XRGB;
			line_bytes_q   <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PIXEL_FORMAT: pixel_format_q <= cfg_data[FMT_W-1:0];
				REG_LINE_BYTES:   line_bytes_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_item = in_item_t'(s_tdata[$bits(in_item_t)-1:0]);

	gprw_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_item      (in_item),
		.pixel_format (pixel_format_q),
		.line_bytes   (line_bytes_q),
		.row_valid    (row_valid),
		.row_ready    (row_ready),
		.row          (row)
	);

	for (genvar g = 0; g < GLYPH_WIDTH; g++) begin : g_lane
		gprw_lane u_lane (
			.row    (row),
			.col    (COL_W'(g)),
			.pix_on (row.glyph_bits[GLYPH_WIDTH-1-g]),
			.pix    (pix[g])
		);
	end

	gprw_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.row_valid  (row_valid),
		.row_ready  (row_ready),
		.row_bcount (row.byte_count),
		.pix        (pix),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule

`default_nettype wire

FILE: src/gprw_checker.sv
// ----------------------------------------------------------------------------
// gprw_checker
// Port-level checks for the glyph row pixel writer.
// ----------------------------------------------------------------------------
`default_nettype none

module gprw_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           m_tvalid,
	input  wire logic                           m_tready,
	input  wire logic [gprw_pkg::OUT_DATA_W-1:0] m_tdata,
	input  wire logic                           m_tlast
);
	import gprw_pkg::*;

	localparam logic [COL_W-1:0] LAST_COL = COL_W'(GLYPH_WIDTH - 1);

	logic                    xfer;
	logic [COL_W-1:0]        beat_q;
	logic [BADDR_W-1:0]      next_addr_q;
	logic [BADDR_W-1:0]      addr;
	logic [BCOUNT_W-1:0]     bc;

	assign xfer = m_tvalid && m_tready;
	assign addr = m_tdata[BADDR_W-1:0];
	assign bc   = m_tdata[BADDR_W+WORD_W +: BCOUNT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q      <= '0;
			next_addr_q <= '0;
		end else if (xfer) begin
			beat_q      <= beat_q + 1'b1;
			next_addr_q <= addr + BADDR_W'(bc);
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output changed while stalled");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		xfer |-> (m_tlast == (beat_q == LAST_COL)))
		else $error("tlast not on eighth pixel");

	a_bcount: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (bc == BC_XRGB || bc == BC_RGB565 || bc == BC_PAL8))
		else $error("illegal byte count");

	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && beat_q != '0 |-> addr == next_addr_q)
		else $error("pixel address step mismatch");

endmodule

bind glyph_row_pixel_writer gprw_checker u_gprw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

`default_nettype wire

FILE: verif/tb_glyph_row_pixel_writer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_glyph_row_pixel_writer
// Self-checking testbench for the glyph row pixel writer.
// ----------------------------------------------------------------------------
// Glyph rows are queued by a sequencer and sent through the input stream by a
// clocked driver. Each accepted row is turned into its expected pixel writes,
// eight or none, which a clocked monitor compares with the output stream. The run
// steps through all pixel formats, including the unused one, and several line
// widths. Both sides idle at random, and once the output holds off long
// enough to back up the input.

module tb_glyph_row_pixel_writer;

	import gprw_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic [FMT_W-1:0]     FMT_NONE   = 2'd3;
	localparam int STALL_AT     = 190;
	localparam int STALL_CYCLES = 400;
	localparam int QUIET_CYCLES = 24;

	typedef struct packed {
		logic [BADDR_W-1:0]  addr;
		logic [WORD_W-1:0]   word;
		logic [BCOUNT_W-1:0] count;
		logic                last;
	} pixel_write_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [LINE_W-1:0]     cfg_data = '0;

	in_item_t     pending_rows[$];
	pixel_write_t expected_writes[$];
	logic [FMT_W-1:0]  fmt_cfg = FMT_XRGB;
	logic [LINE_W-1:0] line_cfg = '0;
	int src_idle_pct = 0;
	int sink_idle_pct = 0;
	int rows_accepted = 0;
	int errors = 0;
	int stall_left = 0;
	bit stall_done = 0;

	glyph_row_pixel_writer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void predict_pixel_writes(in_item_t it);
		logic [63:0] amask;
		logic [63:0] base;
		logic [63:0] addr;
		logic [2:0]  bpp;
		logic [23:0] fg;
		pixel_write_t w;
		amask = (64'd1 << ADDRESS_BITS) - 64'd1;
		if (fmt_cfg == FMT_NONE || int'(it.row_index) >= GLYPH_HEIGHT)
			return;
		case (fmt_cfg)
			FMT_XRGB: begin
				bpp = BC_XRGB;
				fg = it.fg_color;
			end
			FMT_RGB565: begin
				bpp = BC_RGB565;
				fg = {8'd0, it.fg_color[23:19], it.fg_color[15:10], it.fg_color[7:3]};
			end
			default: begin
				bpp = BC_PAL8;
				fg = {16'd0, it.fg_color[7:0]};
			end
		endcase
		base = ((64'(it.char_y) + 64'(it.row_index)) * 64'(line_cfg)) & amask;
		for (int col = 0; col < GLYPH_WIDTH; col++) begin
			addr = (base + (64'(it.char_x) + 64'(col)) * 64'(bpp)) & amask;
			w.addr = addr[BADDR_W-1:0];
			w.word = it.glyph_bits[GLYPH_WIDTH-1-col] ? fg : 24'h000000;
			w.count = bpp;
			w.last = (col == GLYPH_WIDTH - 1);
			expected_writes.push_back(w);
		end
	endfunction

	// input driver
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			predict_pixel_writes(in_item_t'(s_tdata[$bits(in_item_t)-1:0]));
			rows_accepted++;
		end
		if (arst_n && (!s_tvalid || s_tready)) begin
			if (pending_rows.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				s_tdata <= {{(IN_DATA_W - $bits(in_item_t)){1'b0}}, pending_rows.pop_front()};
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// long output hold-off
	always @(posedge clk) begin
		if (!stall_done && rows_accepted >= STALL_AT) begin
			stall_left <= STALL_CYCLES;
			stall_done <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end
	end

	// output monitor
	always @(posedge clk) begin
		pixel_write_t exp_w;
		if (m_tvalid && m_tready) begin
			if (expected_writes.size() == 0) begin
				$error("unexpected pixel write: addr %0h word %0h", m_tdata[25:0],
					m_tdata[49:26]);
				errors++;
			end else begin
				exp_w = expected_writes.pop_front();
				if (m_tdata[25:0] !== exp_w.addr) begin
					$error("byte_address: expected %0h, got %0h", exp_w.addr, m_tdata[25:0]);
					errors++;
				end
				if (m_tdata[49:26] !== exp_w.word) begin
					$error("pixel_word: expected %0h, got %0h", exp_w.word, m_tdata[49:26]);
					errors++;
				end
				if (m_tdata[52:50] !== exp_w.count) begin
					$error("byte_count: expected %0d, got %0d", exp_w.count, m_tdata[52:50]);
					errors++;
				end
				if (m_tlast !== exp_w.last) begin
					$error("last_pixel: expected %0b, got %0b", exp_w.last, m_tlast);
					errors++;
				end
			end
		end
		if (arst_n)
			m_tready <= (stall_left == 0) && ($urandom_range(99) >= sink_idle_pct);
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LINE_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_PIXEL_FORMAT)
			fmt_cfg = val[FMT_W-1:0];
		else if (idx == REG_LINE_BYTES)
			line_cfg = val;
	endtask

	task automatic wait_drained();
		while (pending_rows.size() != 0 || s_tvalid || expected_writes.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic set_format(input logic [FMT_W-1:0] fmt);
		write_reg(REG_PIXEL_FORMAT, {13'($urandom_range(8191)), fmt});
	endtask

	function automatic void queue_row(input logic [11:0] cx, input logic [11:0] cy,
			input logic [3:0] row, input logic [7:0] bits, input logic [23:0] color);
		in_item_t it;
		it.char_x = cx;
		it.char_y = cy;
		it.row_index = row;
		it.glyph_bits = bits;
		it.fg_color = color;
		pending_rows.push_back(it);
	endfunction

	function automatic logic [11:0] pick_coord();
		case ($urandom_range(7))
			0: return 12'd0;
			1: return 12'hFFF;
			default: return 12'($urandom);
		endcase
	endfunction

	function automatic void queue_random(input int n);
		for (int i = 0; i < n; i++)
			queue_row(pick_coord(), pick_coord(), 4'($urandom_range(15)),
				8'($urandom), 24'($urandom));
	endfunction

	task automatic set_idle(input int src, input int sink);
		src_idle_pct = src;
		sink_idle_pct = sink;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset configuration: XRGB, zero line width
		set_idle(10, 85);
		queue_row(12'd0, 12'd0, 4'd0, 8'hFF, 24'hFFFFFF);
		queue_row(12'hFFF, 12'hFFF, 4'd15, 8'h00, 24'h123456);
		queue_row(12'd1, 12'd2, 4'd3, 8'h80, 24'hA5C3E1);
		queue_row(12'd100, 12'd7, 4'd8, 8'h01, 24'h000000);
		queue_row(12'h555, 12'hAAA, 4'd5, 8'hA5, 24'h5A5A5A);
		queue_row(12'hAAA, 12'h555, 4'd10, 8'h5A, 24'hFF00FF);
		wait_drained();

		// line width of 16384 bytes, address wraps at the far corner
		set_format(FMT_XRGB);
		write_reg(REG_LINE_BYTES, 15'd16384);
		queue_row(12'hFFF, 12'hFFF, 4'd15, 8'hFF, 24'hFFFFFF);
		queue_row(12'd0, 12'hFFF, 4'd0, 8'h3C, 24'h0F0F0F);
		queue_row(12'hFFF, 12'd0, 4'd15, 8'hC3, 24'hF0F0F0);
		queue_row(12'hFF8, 12'hFF0, 4'd15, 8'h81, 24'h00FF00);
		queue_row(12'd0, 12'd0, 4'd1, 8'h7E, 24'h0000FF);
		queue_row(12'd3000, 12'd4000, 4'd9, 8'hFF, 24'hFF0000);
		queue_random(30);
		wait_drained();

		// RGB565 with line width at its full 15 bits; sender pauses midway
		set_format(FMT_RGB565);
		write_reg(REG_LINE_BYTES, 15'h7FFF);
		queue_row(12'hFFF, 12'hFFF, 4'd15, 8'hFF, 24'hFFFFFF);
		queue_row(12'd0, 12'd0, 4'd0, 8'hAA, 24'h070307);
		queue_row(12'd17, 12'd33, 4'd2, 8'h55, 24'hF8FCF8);
		queue_row(12'd640, 12'd480, 4'd12, 8'hF0, 24'h084210);
		queue_random(20);
		wait_drained();
		queue_random(20);
		wait_drained();

		set_idle(85, 10);
		// palette index, one byte per line
		set_format(FMT_PAL8);
		write_reg(REG_LINE_BYTES, 15'd1);
		queue_row(12'hFFF, 12'hFFF, 4'd15, 8'hFF, 24'hFFFFFF);
		queue_row(12'd0, 12'd0, 4'd0, 8'h0F, 24'hABCD00);
		queue_row(12'd5, 12'd9, 4'd7, 8'h96, 24'h0000FF);
		queue_row(12'd2048, 12'd1024, 4'd4, 8'h69, 24'hFFFF80);
		queue_random(20);
		wait_drained();

		// unused format: rows are consumed without output
		set_format(FMT_NONE);
		write_reg(REG_LINE_BYTES, 15'd640);
		queue_row(12'd10, 12'd20, 4'd3, 8'hFF, 24'hFFFFFF);
		queue_row(12'hFFF, 12'hFFF, 4'd15, 8'hA5, 24'h123456);
		queue_random(10);
		wait_drained();

		// back to XRGB at zero width; a write to an unknown index changes nothing
		set_format(FMT_XRGB);
		write_reg(REG_LINE_BYTES, 15'd0);
		write_reg(REG_UNUSED, 15'($urandom));
		queue_random(40);
		wait_drained();

		set_idle(0, 0);
		// random settings, output holds off long enough to back up the input
		set_format(2'($urandom_range(2)));
		write_reg(REG_LINE_BYTES, 15'($urandom));
		queue_random(40);
		wait_drained();

		set_format(FMT_RGB565);
		write_reg(REG_LINE_BYTES, 15'd2560);
		queue_random(20);
		wait_drained();

		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
